>>> hw/rtl/ps2_wheel_mouse_packet_decoder_core_macros.svh
// ----------------------------------------------------------------------------
// PS/2 wheel-mouse packet decoder assertion macros
// Clocked assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef PS2_WHEEL_MOUSE_PACKET_DECODER_CORE_MACROS_SVH
`define PS2_WHEEL_MOUSE_PACKET_DECODER_CORE_MACROS_SVH

// property checked on every edge outside reset
`define PS2WM_ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define PS2WM_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/ps2wm_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 wheel-mouse packet decoder package
// Shared types and constants of the decoder.
// ----------------------------------------------------------------------------
package ps2wm_pkg;

    localparam int BYTE_W  = 8;
    localparam int BTN_W   = 3;
    localparam int DELTA_W = 9;
    localparam int WHEEL_W = 4;
    localparam int POS_W   = 32;
    localparam int CODE_W  = 4;
    localparam int SLOT_W  = 2;
    localparam int BPOS_W  = 2;

    localparam int XSIGN_BIT = 4;
    localparam int YSIGN_BIT = 5;

    localparam logic [BPOS_W-1:0] LAST_BYTE = 2'd3;
    localparam logic [CODE_W-1:0] EVT_NONE  = 4'd0;
    localparam logic [CODE_W-1:0] EVT_WHEEL = 4'd8;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef logic        [BYTE_W-1:0]  t_byte;
    typedef logic        [BTN_W-1:0]   t_btn;
    typedef logic signed [DELTA_W-1:0] t_delta;
    typedef logic signed [WHEEL_W-1:0] t_wheel;
    typedef logic signed [POS_W-1:0]   t_pos;
    typedef logic        [CODE_W-1:0]  t_code;
    typedef logic        [SLOT_W-1:0]  t_slot;

    typedef struct packed {
        t_btn   btn;
        t_delta dx;
        t_delta dy;
        t_wheel wheel;
    } t_pkt;

endpackage

>>> hw/rtl/ps2wm_if.sv
// ----------------------------------------------------------------------------
// PS/2 wheel-mouse decoder channels
// Valid/ready channels for received bytes and decoded events.
// ----------------------------------------------------------------------------
interface ps2wm_byte_if;
    import ps2wm_pkg::*;

    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface ps2wm_evt_if;
    import ps2wm_pkg::*;

    logic  valid;
    logic  ready;
    t_pos  pos_x;
    t_pos  pos_y;
    t_code event_code;
    t_slot event_slot;

    modport source (output valid, output pos_x, output pos_y, output event_code,
                    output event_slot, input ready);
    modport sink (input valid, input pos_x, input pos_y, input event_code,
                  input event_slot, output ready);
endinterface

>>> hw/rtl/ps2wm_front.sv
// ----------------------------------------------------------------------------
// PS/2 wheel-mouse decoder front end
// Frames received bytes into packets and extracts buttons, deltas and wheel.
// ----------------------------------------------------------------------------
module ps2wm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ps2wm_byte_if.sink        i_rx,
    output logic              o_push_valid,
    input  logic              i_push_ready,
    output ps2wm_pkg::t_pkt   o_push_pkt
);
    import ps2wm_pkg::*;

    logic [BPOS_W-1:0] r_bpos;
    logic [BPOS_W-1:0] n_bpos;
    t_byte             r_b0;
    t_byte             r_b1;
    t_byte             r_b2;
    logic              last;
    logic              accept;

    assign last       = (r_bpos == LAST_BYTE);
    assign i_rx.ready = !last || i_push_ready;
    assign accept     = i_rx.valid && i_rx.ready;
    assign n_bpos     = r_bpos + BPOS_W'(1);

    assign o_push_valid     = i_rx.valid && last;
    assign o_push_pkt.btn   = r_b0[BTN_W-1:0];
    assign o_push_pkt.dx    = {r_b0[XSIGN_BIT], r_b1};
    assign o_push_pkt.dy    = {r_b0[YSIGN_BIT], r_b2};
    assign o_push_pkt.wheel = i_rx.rx_byte[WHEEL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpos <= '0;
        end else if (accept) begin
            r_bpos <= n_bpos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            case (r_bpos)
                2'd0:    r_b0 <= i_rx.rx_byte;
                2'd1:    r_b1 <= i_rx.rx_byte;
                2'd2:    r_b2 <= i_rx.rx_byte;
                default: ;
            endcase
        end
    end
endmodule

>>> hw/rtl/ps2wm_queue.sv
// ----------------------------------------------------------------------------
// PS/2 wheel-mouse decoder packet queue
// Short FIFO between the framing front end and the event back end.
// ----------------------------------------------------------------------------
module ps2wm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  ps2wm_pkg::t_pkt i_push_pkt,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output ps2wm_pkg::t_pkt o_pop_pkt
);
    import ps2wm_pkg::*;

    t_pkt            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_CW-1:0] r_cnt;
    logic            push;
    logic            pop;

    assign o_push_ready = (r_cnt != Q_CW'(Q_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_pkt    = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wr + Q_AW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rd + Q_AW'(1);
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + Q_CW'(1);
                2'b01:   r_cnt <= r_cnt - Q_CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_pkt;
        end
    end
endmodule

>>> hw/rtl/ps2wm_back.sv
// ----------------------------------------------------------------------------
// PS/2 wheel-mouse decoder back end
// Button edges, wheel events, position update and registered event output.
// ----------------------------------------------------------------------------
module ps2wm_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_pop_valid,
    output logic            o_pop_ready,
    input  ps2wm_pkg::t_pkt i_pop_pkt,
    ps2wm_evt_if.source     o_evt
);
    import ps2wm_pkg::*;

    t_btn  r_prev;
    t_pos  r_pos_x;
    t_pos  r_pos_y;
    t_slot r_slot;
    logic  r_valid;
    t_code r_code;
    t_slot r_ev_slot;

    t_btn  chg;
    t_btn  press;
    t_btn  release_m;
    t_code edge_code;
    t_code n_code;
    t_pos  dx32;
    t_pos  dy32;
    t_pos  n_pos_x;
    t_pos  n_pos_y;
    logic  wheel_evt;
    logic  take;

    always_comb begin
        chg       = i_pop_pkt.btn ^ r_prev;
        press     = chg & i_pop_pkt.btn;
        release_m = chg & r_prev;
        edge_code = {press, 1'b0} | {1'b0, release_m};
        wheel_evt = (edge_code == EVT_NONE) && (i_pop_pkt.wheel != '0);
        n_code    = wheel_evt ? EVT_WHEEL : edge_code;
        dx32      = wheel_evt ? POS_W'(i_pop_pkt.wheel) : POS_W'(i_pop_pkt.dx);
        dy32      = POS_W'(i_pop_pkt.dy);
        n_pos_x   = r_pos_x + dx32;
        n_pos_y   = r_pos_y + dy32;
    end

    assign o_pop_ready = !r_valid || o_evt.ready;
    assign take        = i_pop_valid && o_pop_ready;

    assign o_evt.valid      = r_valid;
    assign o_evt.pos_x      = r_pos_x;
    assign o_evt.pos_y      = r_pos_y;
    assign o_evt.event_code = r_code;
    assign o_evt.event_slot = r_ev_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_prev  <= '0;
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_slot  <= '0;
        end else begin
            if (take) begin
                r_valid <= 1'b1;
                r_prev  <= i_pop_pkt.btn;
                r_pos_x <= n_pos_x;
                r_pos_y <= n_pos_y;
                r_slot  <= r_slot + SLOT_W'(1);
            end else if (o_evt.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_code    <= n_code;
            r_ev_slot <= r_slot;
        end
    end
endmodule

>>> hw/rtl/ps2_wheel_mouse_packet_decoder_core.sv
// ----------------------------------------------------------------------------
// PS/2 wheel-mouse packet decoder core
// Groups received mouse bytes into four-byte packets and emits position events.
// ----------------------------------------------------------------------------
// Channels: i_rx carries one received byte per word; o_evt carries one event
// word (pos_x, pos_y, event_code, event_slot) for every fourth byte.
// Bytes are taken at one per cycle while i_rx.ready is high. The front end frames bytes and, on the
// fourth one, pushes the decoded packet into a two-entry queue; the back end
// pops it, updates buttons and positions and loads the output register.
// The fourth byte enters the queue as it is accepted; the back end adds the
// packet to the 32-bit positions and registers the event. Throughput: one
// byte per cycle while i_rx.ready is high; one event per four bytes.
// If o_evt stalls, the output register holds its event, the queue absorbs up
// to two more packets, and after that i_rx.ready drops only on a fourth byte.
// Reset clears byte framing, previous buttons, positions and slot counter,
// and empties the queue and the output register.
// ----------------------------------------------------------------------------
module ps2_wheel_mouse_packet_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ps2wm_byte_if.sink  i_rx,
    ps2wm_evt_if.source o_evt
);
    import ps2wm_pkg::*;

    logic push_valid;
    logic push_ready;
    t_pkt push_pkt;
    logic pop_valid;
    logic pop_ready;
    t_pkt pop_pkt;

    ps2wm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (i_rx),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_pkt   (push_pkt)
    );

    ps2wm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_pkt   (push_pkt),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_pkt    (pop_pkt)
    );

    ps2wm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_pkt   (pop_pkt),
        .o_evt       (o_evt)
    );
endmodule

>>> hw/rtl/ps2wm_checker.sv
// ----------------------------------------------------------------------------
// PS/2 wheel-mouse decoder port checker
// Port-level checks on the event channel, bound to the core.
// ----------------------------------------------------------------------------
`include "ps2_wheel_mouse_packet_decoder_core_macros.svh"

module ps2wm_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_evt_valid,
    input logic                 i_evt_ready,
    input ps2wm_pkg::t_pos      i_pos_x,
    input ps2wm_pkg::t_pos      i_pos_y,
    input ps2wm_pkg::t_code     i_event_code,
    input ps2wm_pkg::t_slot     i_event_slot
);
    import ps2wm_pkg::*;

    t_slot r_next_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_slot <= '0;
        end else if (i_evt_valid && i_evt_ready) begin
            r_next_slot <= r_next_slot + SLOT_W'(1);
        end
    end

    `PS2WM_ASSERT_ALWAYS(a_rst_no_evt, i_clk, !i_rst_n |=> !i_evt_valid, "event valid after reset")

    `PS2WM_ASSERT_CLK(a_stall_hold, i_clk, i_rst_n, i_evt_valid && !i_evt_ready |=> i_evt_valid && $stable(i_pos_x) && $stable(i_pos_y) && $stable(i_event_code) && $stable(i_event_slot), "stalled event changed")

    `PS2WM_ASSERT_CLK(a_slot_seq, i_clk, i_rst_n, i_evt_valid |-> i_event_slot == r_next_slot, "event slot out of sequence")
endmodule

bind ps2_wheel_mouse_packet_decoder_core ps2wm_checker u_ps2wm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_evt_valid  (o_evt.valid),
    .i_evt_ready  (o_evt.ready),
    .i_pos_x      (o_evt.pos_x),
    .i_pos_y      (o_evt.pos_y),
    .i_event_code (o_evt.event_code),
    .i_event_slot (o_evt.event_slot)
);

>>> bench/ps2_wheel_mouse_packet_decoder_core_tb.sv
// ----------------------------------------------------------------------------
// PS/2 wheel-mouse packet decoder testbench
// Sends mouse bytes through the byte channel, predicts every fourth-byte
// event (buttons, positions, wheel, ring slot), and checks each event word
// in order. Both channels idle at random, the event side holds off long
// enough to back up the input, and the sender drains once mid-run.
// ----------------------------------------------------------------------------
module ps2_wheel_mouse_packet_decoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ps2wm_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RAND_PACKETS = 480;

    typedef struct packed {
        t_pos  pos_x;
        t_pos  pos_y;
        t_code event_code;
        t_slot event_slot;
    } t_evt_word;

    class event_scoreboard;
        t_byte          held [3];
        logic [BPOS_W-1:0] byte_idx;
        t_btn           last_btn;
        t_pos           pos_x;
        t_pos           pos_y;
        t_slot          slot;
        t_evt_word      expected_q [$];
        int             mismatches;

        function void clear();
            byte_idx   = '0;
            last_btn   = '0;
            pos_x      = '0;
            pos_y      = '0;
            slot       = '0;
            mismatches = 0;
            for (int i = 0; i < 3; i++) held[i] = '0;
            expected_q.delete();
        endfunction

        function void note_byte(t_byte b);
            t_btn         btn;
            t_btn         chg;
            t_btn         press;
            t_btn         release_mask;
            t_delta       dx9;
            t_delta       dy9;
            t_wheel       wheel;
            t_pos         dx;
            t_pos         dy;
            t_code        code;
            t_evt_word    ev;
            if (byte_idx != LAST_BYTE) begin
                held[byte_idx] = b;
                byte_idx       = byte_idx + BPOS_W'(1);
                return;
            end
            byte_idx     = '0;
            btn          = held[0][BTN_W-1:0];
            chg          = btn ^ last_btn;
            press        = chg & btn;
            release_mask = chg & last_btn;
            last_btn     = btn;
            dx9          = {held[0][XSIGN_BIT], held[1]};
            dy9          = {held[0][YSIGN_BIT], held[2]};
            dx           = POS_W'(dx9);
            dy           = POS_W'(dy9);
            wheel        = b[WHEEL_W-1:0];
            code         = t_code'({press, 1'b0}) | t_code'(release_mask);
            if (code == EVT_NONE && wheel != '0) begin
                code = EVT_WHEEL;
                dx   = POS_W'(wheel);
            end
            pos_x         = pos_x + dx;
            pos_y         = pos_y + dy;
            ev.pos_x      = pos_x;
            ev.pos_y      = pos_y;
            ev.event_code = code;
            ev.event_slot = slot;
            slot          = slot + SLOT_W'(1);
            expected_q.push_back(ev);
        endfunction

        function void check_event(t_evt_word got);
            t_evt_word want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected event word: x=%0d y=%0d code=%0d slot=%0d",
                             got.pos_x, got.pos_y, got.event_code, got.event_slot);
                return;
            end
            want = expected_q.pop_front();
            if (got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
                got.event_code !== want.event_code ||
                got.event_slot !== want.event_slot) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch exp x=%0d y=%0d c=%0d s=%0d got x=%0d y=%0d c=%0d s=%0d",
                             want.pos_x, want.pos_y, want.event_code, want.event_slot,
                             got.pos_x, got.pos_y, got.event_code, got.event_slot);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    ps2wm_byte_if rx_if ();
    ps2wm_evt_if  evt_if ();

    ps2_wheel_mouse_packet_decoder_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_evt   (evt_if)
    );

    event_scoreboard board;
    bit              quiet;
    bit              hold_request;
    int              cycles;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_evt_word got;
        if (i_rst_n && evt_if.valid && evt_if.ready) begin
            got.pos_x      = evt_if.pos_x;
            got.pos_y      = evt_if.pos_y;
            got.event_code = evt_if.event_code;
            got.event_slot = evt_if.event_slot;
            board.check_event(got);
        end
    end

    // event side: random back-pressure plus one long hold-off on request
    initial begin
        evt_if.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                evt_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if (quiet)
                evt_if.ready <= 1'b1;
            else
                evt_if.ready <= ($urandom_range(99) >= 8);
            @(posedge i_clk);
        end
    end

    task automatic send_byte(input t_byte b);
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
        board.note_byte(b);
        if (!quiet && $urandom_range(99) < 8) begin
            rx_if.valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic send_packet(input t_byte b0, input t_byte b1, input t_byte b2,
                               input t_byte b3);
        send_byte(b0);
        send_byte(b1);
        send_byte(b2);
        send_byte(b3);
    endtask

    function automatic t_byte delta_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return t_byte'($urandom_range(255));
        endcase
    endfunction

    initial begin
        t_byte b0;
        t_btn  btn;
        board = new();
        board.clear();
        quiet         = 1'b0;
        hold_request  = 1'b0;
        cycles        = 0;
        i_rst_n       = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: all pressed, full deltas both signs, ignored bits, masks, wheel ends
        send_packet(8'h17, 8'h00, 8'hFF, 8'h00);
        send_packet(8'hE8, 8'hFF, 8'h00, 8'hF0);
        send_packet(8'h01, 8'h80, 8'h80, 8'h07);
        send_packet(8'h02, 8'h01, 8'h01, 8'h08);
        send_packet(8'h01, 8'h7F, 8'h00, 8'h3C);
        send_packet(8'h31, 8'h7F, 8'hFF, 8'h58);
        send_packet(8'h01, 8'h00, 8'h00, 8'hA7);

        for (int p = 0; p < RAND_PACKETS; p++) begin
            if (p == 120)
                hold_request = 1'b1;
            if (p == 240) begin
                rx_if.valid <= 1'b0;
                while (board.expected_q.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end
            quiet = (p >= 300 && p < 400);
            btn   = $urandom_range(1) ? board.last_btn : t_btn'($urandom_range(7));
            b0    = t_byte'($urandom_range(255));
            b0[BTN_W-1:0] = btn;
            send_packet(b0, delta_byte(), delta_byte(), t_byte'($urandom_range(255)));
        end
        rx_if.valid <= 1'b0;

        while (board.expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (board.mismatches == 0 && board.expected_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ps2wm_pkg.sv
hw/rtl/ps2wm_if.sv
hw/rtl/ps2wm_front.sv
hw/rtl/ps2wm_queue.sv
hw/rtl/ps2wm_back.sv
hw/rtl/ps2_wheel_mouse_packet_decoder_core.sv
hw/rtl/ps2wm_checker.sv
bench/ps2_wheel_mouse_packet_decoder_core_tb.sv
